@@ rtl/assert_macros.svh @@
// Assertion helpers, clocked and disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/dndc_pkg.sv @@
package dndc_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned JDN_W   = 23;
  localparam int unsigned IDX_W   = 4;

  localparam int unsigned NSTAGE  = 11;

  localparam int unsigned JD_MIN     = 1721424;
  localparam int unsigned JD_MAX     = 5373484;
  localparam int unsigned GREG_START = 2299161;

  localparam int unsigned EPOCH_YEAR    = 4800;
  localparam int unsigned GREG_OFS      = 32045;
  localparam int unsigned JUL_OFS       = 32083;
  localparam int unsigned GREG_BACK_OFS = 32044;
  localparam int unsigned JUL_BACK_OFS  = 32082;
  localparam int unsigned DAYS_400Y     = 146097;
  localparam int unsigned DAYS_4Y       = 1461;
  localparam int unsigned DAYS_5M       = 153;
  localparam int unsigned DAYS_YEAR     = 365;
  localparam int unsigned CENTURY       = 100;
  localparam int unsigned MONTHS        = 12;
  localparam int unsigned MAR_SHIFT     = 3;
  localparam int unsigned FEB           = 2;
  localparam int unsigned LATE_MONTH    = 10;
  localparam int unsigned STEMS         = 10;
  localparam int unsigned BRANCHES      = 12;
  localparam int unsigned STEM_OFS      = 9;
  localparam int unsigned BRANCH_OFS    = 1;
  localparam int unsigned FRAC_MUL      = 5;
  localparam int unsigned FRAC_ADD      = 2;

  // internal widths
  localparam int unsigned EY_W  = YEAR_W + 1;
  localparam int unsigned Y4_W  = EY_W - 2;
  localparam int unsigned JX_W  = JDN_W + 1;
  localparam int unsigned OFS_W = 9;
  localparam int unsigned CEN_W = 8;
  localparam int unsigned Y400_W = 6;
  localparam int unsigned C_W   = 22;
  localparam int unsigned D_W   = 14;
  localparam int unsigned E_W   = 9;
  localparam int unsigned XM_W  = 12;
  localparam int unsigned D4Y_W = 11;

  // reciprocals for constant division, exact over the operand widths used
  localparam int unsigned RCP100_SH = 22;
  localparam int unsigned RCP100_W  = 16;
  localparam logic [RCP100_W-1:0] RCP100 =
    RCP100_W'(((64'd1 << RCP100_SH) + 64'(CENTURY) - 64'd1) / 64'(CENTURY));

  localparam int unsigned RCP_400Y_SH = 43;
  localparam int unsigned RCP_400Y_W  = 26;
  localparam logic [RCP_400Y_W-1:0] RCP_400Y =
    RCP_400Y_W'(((64'd1 << RCP_400Y_SH) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y));

  localparam int unsigned RCP_4Y_SH = 35;
  localparam int unsigned RCP_4Y_W  = 25;
  localparam logic [RCP_4Y_W-1:0] RCP_4Y =
    RCP_4Y_W'(((64'd1 << RCP_4Y_SH) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));

  localparam int unsigned RCP_5M_SH = 20;
  localparam int unsigned RCP_5M_W  = 13;
  localparam logic [RCP_5M_W-1:0] RCP_5M =
    RCP_5M_W'(((64'd1 << RCP_5M_SH) + 64'(DAYS_5M) - 64'd1) / 64'(DAYS_5M));

  localparam int unsigned RCP_STEM_SH = 28;
  localparam int unsigned RCP_STEM_W  = 25;
  localparam logic [RCP_STEM_W-1:0] RCP_STEM =
    RCP_STEM_W'(((64'd1 << RCP_STEM_SH) + 64'(STEMS) - 64'd1) / 64'(STEMS));

  localparam int unsigned RCP_BRANCH_SH = 28;
  localparam int unsigned RCP_BRANCH_W  = 25;
  localparam logic [RCP_BRANCH_W-1:0] RCP_BRANCH =
    RCP_BRANCH_W'(((64'd1 << RCP_BRANCH_SH) + 64'(BRANCHES) - 64'd1) / 64'(BRANCHES));

  localparam int unsigned P100_W = EY_W + RCP100_W;
  localparam int unsigned PB_W   = JDN_W + 2 + RCP_400Y_W;
  localparam int unsigned PQ_W   = JX_W + RCP_STEM_W;
  localparam int unsigned PBD_W  = CEN_W + 18;
  localparam int unsigned PD_W   = C_W + 2 + RCP_4Y_W;
  localparam int unsigned PE_W   = D_W + D4Y_W;
  localparam int unsigned PM_W   = XM_W + RCP_5M_W;

  // days before each March-based month: (153 * m + 2) / 5
  localparam logic [OFS_W-1:0] MONTH_OFS [16] = '{
    9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153, 9'd184, 9'd214,
    9'd245, 9'd275, 9'd306, 9'd337, 9'd367, 9'd398, 9'd428, 9'd459
  };

endpackage

@@ rtl/dndc_in_if.sv @@
interface dndc_in_if import dndc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [DAY_W-1:0]   in_day;
  logic [MONTH_W-1:0] in_month;
  logic [YEAR_W-1:0]  in_year;
  logic [JDN_W-1:0]   in_day_number;

  modport source (output valid, op, in_day, in_month, in_year, in_day_number, input ready);
  modport sink   (input valid, op, in_day, in_month, in_year, in_day_number, output ready);
endinterface

@@ rtl/dndc_out_if.sv @@
interface dndc_out_if import dndc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [JDN_W-1:0]   day_number;
  logic [DAY_W-1:0]   out_day;
  logic [MONTH_W-1:0] out_month;
  logic [YEAR_W-1:0]  out_year;
  logic [IDX_W-1:0]   day_stem;
  logic [IDX_W-1:0]   branch_idx;
  logic               out_of_range;

  modport source (output valid, day_number, out_day, out_month, out_year, day_stem,
                  branch_idx, out_of_range, input ready);
  modport sink   (input valid, day_number, out_day, out_month, out_year, day_stem,
                  branch_idx, out_of_range, output ready);
endinterface

@@ rtl/day_number_date_converter.sv @@
// Throughput: one transaction per cycle while the output is ready, set by an
// 11-stage datapath of short constant multiply and add steps; a stage advances
// when the next is empty or moving.
// Reset: rst_ni clears every stage valid flag asynchronously; datapath registers hold
// undefined data until the first transaction passes.
`include "assert_macros.svh"

module day_number_date_converter import dndc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  dndc_in_if.sink   in_i,
  dndc_out_if.source out_o
);

  typedef struct packed {
    logic [JDN_W-1:0] jd;
    logic             oor;
    logic [IDX_W-1:0] stem;
    logic [IDX_W-1:0] branch;
  } tag_t;

  typedef struct packed {
    logic             op;
    logic [JDN_W-1:0] jdn;
    logic [EY_W-1:0]  ey;
    logic [OFS_W-1:0] dofs;
  } st1_t;

  typedef struct packed {
    logic              op;
    logic [JDN_W-1:0]  jdn;
    logic [JDN_W-1:0]  y365;
    logic [Y4_W-1:0]   y4;
    logic [CEN_W-1:0]  y100;
    logic [Y400_W-1:0] y400;
    logic [OFS_W-1:0]  dofs;
  } st2_t;

  typedef struct packed {
    logic             op;
    logic [JDN_W-1:0] jdn;
    logic [JDN_W-1:0] base;
    logic [Y4_W-1:0]  y4;
    logic [Y4_W-1:0]  corr;
  } st3_t;

  typedef struct packed {
    logic [JDN_W-1:0] jd;
  } st4_t;

  typedef struct packed {
    logic [JDN_W-1:0] jd;
    logic             oor;
    logic             greg;
    logic [JDN_W-1:0] a;
    logic [C_W-1:0]   cj;
    logic [JX_W-1:0]  sx;
    logic [JX_W-1:0]  bx;
  } st5_t;

  typedef struct packed {
    logic [JDN_W-1:0] jd;
    logic             oor;
    logic             greg;
    logic [JDN_W-1:0] a;
    logic [C_W-1:0]   cj;
    logic [CEN_W-1:0] b;
    logic [IDX_W-1:0] qs;
    logic [IDX_W-1:0] qb;
    logic [IDX_W-1:0] sx;
    logic [IDX_W-1:0] bx;
  } st6_t;

  typedef struct packed {
    tag_t             tag;
    logic [CEN_W-1:0] b;
    logic [C_W-1:0]   c;
  } st7_t;

  typedef struct packed {
    tag_t             tag;
    logic [CEN_W-1:0] b;
    logic [C_W-1:0]   c;
    logic [D_W-1:0]   d;
  } st8_t;

  typedef struct packed {
    tag_t             tag;
    logic [CEN_W-1:0] b;
    logic [D_W-1:0]   d;
    logic [E_W-1:0]   e;
  } st9_t;

  typedef struct packed {
    tag_t               tag;
    logic [CEN_W-1:0]   b;
    logic [D_W-1:0]     d;
    logic [E_W-1:0]     e;
    logic [MONTH_W-1:0] m;
  } st10_t;

  typedef struct packed {
    logic [JDN_W-1:0]   day_number;
    logic [DAY_W-1:0]   out_day;
    logic [MONTH_W-1:0] out_month;
    logic [YEAR_W-1:0]  out_year;
    logic [IDX_W-1:0]   day_stem;
    logic [IDX_W-1:0]   branch_idx;
    logic               out_of_range;
  } st11_t;

  logic [NSTAGE-1:0] v_q, en;

  st1_t  s1_d,  s1_q;
  st2_t  s2_d,  s2_q;
  st3_t  s3_d,  s3_q;
  st4_t  s4_d,  s4_q;
  st5_t  s5_d,  s5_q;
  st6_t  s6_d,  s6_q;
  st7_t  s7_d,  s7_q;
  st8_t  s8_d,  s8_q;
  st9_t  s9_d,  s9_q;
  st10_t s10_d, s10_q;
  st11_t s11_d, s11_q;

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[NSTAGE-1] = !v_q[NSTAGE-1] || out_o.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_i.ready = en[0];

  // shift the year so that the leap day ends it
  always_comb begin
    logic               early;
    logic [MONTH_W-1:0] mi;
    early = in_i.in_month <= MONTH_W'(FEB);
    mi = early ? in_i.in_month + MONTH_W'(MONTHS - MAR_SHIFT)
               : in_i.in_month - MONTH_W'(MAR_SHIFT);
    s1_d.op   = in_i.op;
    s1_d.jdn  = in_i.in_day_number;
    s1_d.ey   = EY_W'(in_i.in_year) + EY_W'(EPOCH_YEAR) - EY_W'(early);
    s1_d.dofs = OFS_W'(in_i.in_day) + MONTH_OFS[mi];
  end

  always_comb begin
    logic [P100_W-1:0] p100, p400;
    logic [Y4_W-1:0]   y4;
    y4   = s1_q.ey[EY_W-1:2];
    p100 = P100_W'(s1_q.ey) * P100_W'(RCP100);
    p400 = P100_W'(y4) * P100_W'(RCP100);
    s2_d.op   = s1_q.op;
    s2_d.jdn  = s1_q.jdn;
    s2_d.y365 = JDN_W'(s1_q.ey) * JDN_W'(DAYS_YEAR);
    s2_d.y4   = y4;
    s2_d.y100 = CEN_W'(p100 >> RCP100_SH);
    s2_d.y400 = Y400_W'(p400 >> RCP100_SH);
    s2_d.dofs = s1_q.dofs;
  end

  always_comb begin
    s3_d.op   = s2_q.op;
    s3_d.jdn  = s2_q.jdn;
    s3_d.base = s2_q.y365 + JDN_W'(s2_q.dofs);
    s3_d.y4   = s2_q.y4;
    s3_d.corr = s2_q.y4 - Y4_W'(s2_q.y100) + Y4_W'(s2_q.y400);
  end

  // pass the day number through for a day-number input; otherwise fall back to the Julian calendar before the reform
  always_comb begin
    logic [JX_W-1:0] greg, jul;
    greg = JX_W'(s3_q.base) + JX_W'(s3_q.corr) - JX_W'(GREG_OFS);
    jul  = JX_W'(s3_q.base) + JX_W'(s3_q.y4) - JX_W'(JUL_OFS);
    if (s3_q.op) begin
      s4_d.jd = s3_q.jdn;
    end else if (greg < JX_W'(GREG_START)) begin
      s4_d.jd = jul[JDN_W-1:0];
    end else begin
      s4_d.jd = greg[JDN_W-1:0];
    end
  end

  always_comb begin
    s5_d.jd   = s4_q.jd;
    s5_d.oor  = (s4_q.jd < JDN_W'(JD_MIN)) || (s4_q.jd > JDN_W'(JD_MAX));
    s5_d.greg = s4_q.jd >= JDN_W'(GREG_START);
    s5_d.a    = s4_q.jd + JDN_W'(GREG_BACK_OFS);
    s5_d.cj   = C_W'(JX_W'(s4_q.jd) + JX_W'(JUL_BACK_OFS));
    s5_d.sx   = JX_W'(s4_q.jd) + JX_W'(STEM_OFS);
    s5_d.bx   = JX_W'(s4_q.jd) + JX_W'(BRANCH_OFS);
  end

  always_comb begin
    logic [PB_W-1:0] pb;
    logic [PQ_W-1:0] ps, pr;
    pb = PB_W'({s5_q.a, 2'b11}) * PB_W'(RCP_400Y);
    ps = PQ_W'(s5_q.sx) * PQ_W'(RCP_STEM);
    pr = PQ_W'(s5_q.bx) * PQ_W'(RCP_BRANCH);
    s6_d.jd   = s5_q.jd;
    s6_d.oor  = s5_q.oor;
    s6_d.greg = s5_q.greg;
    s6_d.a    = s5_q.a;
    s6_d.cj   = s5_q.cj;
    s6_d.b    = CEN_W'(pb >> RCP_400Y_SH);
    s6_d.qs   = IDX_W'(ps >> RCP_STEM_SH);
    s6_d.qb   = IDX_W'(pr >> RCP_BRANCH_SH);
    s6_d.sx   = s5_q.sx[IDX_W-1:0];
    s6_d.bx   = s5_q.bx[IDX_W-1:0];
  end

  // remainders fit four bits, so work modulo sixteen
  always_comb begin
    logic [PBD_W-1:0] pbd;
    logic [JX_W-1:0]  cg;
    pbd = PBD_W'(s6_q.b) * PBD_W'(DAYS_400Y);
    cg  = JX_W'(s6_q.a) - JX_W'(pbd >> 2);
    s7_d.tag.jd     = s6_q.jd;
    s7_d.tag.oor    = s6_q.oor;
    s7_d.tag.stem   = s6_q.sx - IDX_W'(s6_q.qs * IDX_W'(STEMS));
    s7_d.tag.branch = s6_q.bx - IDX_W'(s6_q.qb * IDX_W'(BRANCHES));
    s7_d.b          = s6_q.greg ? s6_q.b : '0;
    s7_d.c          = s6_q.greg ? C_W'(cg) : s6_q.cj;
  end

  always_comb begin
    logic [PD_W-1:0] pd;
    pd = PD_W'({s7_q.c, 2'b11}) * PD_W'(RCP_4Y);
    s8_d.tag = s7_q.tag;
    s8_d.b   = s7_q.b;
    s8_d.c   = s7_q.c;
    s8_d.d   = D_W'(pd >> RCP_4Y_SH);
  end

  always_comb begin
    logic [PE_W-1:0] pe;
    pe = PE_W'(s8_q.d) * PE_W'(DAYS_4Y);
    s9_d.tag = s8_q.tag;
    s9_d.b   = s8_q.b;
    s9_d.d   = s8_q.d;
    s9_d.e   = E_W'(s8_q.c - C_W'(pe >> 2));
  end

  always_comb begin
    logic [XM_W-1:0] xm;
    logic [PM_W-1:0] pm;
    xm = XM_W'(s9_q.e) * XM_W'(FRAC_MUL) + XM_W'(FRAC_ADD);
    pm = PM_W'(xm) * PM_W'(RCP_5M);
    s10_d.tag = s9_q.tag;
    s10_d.b   = s9_q.b;
    s10_d.d   = s9_q.d;
    s10_d.e   = s9_q.e;
    s10_d.m   = MONTH_W'(pm >> RCP_5M_SH);
  end

  // undo the March shift; drop the date when out of range
  always_comb begin
    logic                late;
    logic [DAY_W-1:0]    dd;
    logic [MONTH_W-1:0]  mm;
    logic [YEAR_W-1:0]   yy;
    late = s10_q.m >= MONTH_W'(LATE_MONTH);
    dd   = DAY_W'(s10_q.e - E_W'(MONTH_OFS[s10_q.m]) + E_W'(1));
    mm   = late ? s10_q.m - MONTH_W'(MONTHS - MAR_SHIFT) : s10_q.m + MONTH_W'(MAR_SHIFT);
    yy   = YEAR_W'(s10_q.b) * YEAR_W'(CENTURY) + YEAR_W'(s10_q.d)
           - YEAR_W'(EPOCH_YEAR) + YEAR_W'(late);
    s11_d.day_number   = s10_q.tag.jd;
    s11_d.out_day      = s10_q.tag.oor ? '0 : dd;
    s11_d.out_month    = s10_q.tag.oor ? '0 : mm;
    s11_d.out_year     = s10_q.tag.oor ? '0 : yy;
    s11_d.day_stem     = s10_q.tag.stem;
    s11_d.branch_idx   = s10_q.tag.branch;
    s11_d.out_of_range = s10_q.tag.oor;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_q <= s1_d;
    end
    if (en[1]) begin
      s2_q <= s2_d;
    end
    if (en[2]) begin
      s3_q <= s3_d;
    end
    if (en[3]) begin
      s4_q <= s4_d;
    end
    if (en[4]) begin
      s5_q <= s5_d;
    end
    if (en[5]) begin
      s6_q <= s6_d;
    end
    if (en[6]) begin
      s7_q <= s7_d;
    end
    if (en[7]) begin
      s8_q <= s8_d;
    end
    if (en[8]) begin
      s9_q <= s9_d;
    end
    if (en[9]) begin
      s10_q <= s10_d;
    end
    if (en[10]) begin
      s11_q <= s11_d;
    end
  end

  assign out_o.valid        = v_q[NSTAGE-1];
  assign out_o.day_number   = s11_q.day_number;
  assign out_o.out_day      = s11_q.out_day;
  assign out_o.out_month    = s11_q.out_month;
  assign out_o.out_year     = s11_q.out_year;
  assign out_o.day_stem     = s11_q.day_stem;
  assign out_o.branch_idx   = s11_q.branch_idx;
  assign out_o.out_of_range = s11_q.out_of_range;

  `ASSERT_IMPLY(stall_only_when_full_a, clk_i, rst_ni, !in_i.ready,
    (&v_q) && !out_o.ready, "input stalled while the pipeline has a free stage")

  `ASSERT_IMPLY(oor_flag_a, clk_i, rst_ni, out_o.valid,
    out_o.out_of_range == ((out_o.day_number < JDN_W'(JD_MIN)) ||
    (out_o.day_number > JDN_W'(JD_MAX))), "range flag disagrees with day number")

  `ASSERT_IMPLY(oor_zero_date_a, clk_i, rst_ni, out_o.valid && out_o.out_of_range,
    (out_o.out_day == '0) && (out_o.out_month == '0) && (out_o.out_year == '0),
    "date fields not cleared for an out-of-range day number")

  `ASSERT_IMPLY(date_legal_a, clk_i, rst_ni, out_o.valid && !out_o.out_of_range,
    (out_o.out_day != '0) && (out_o.out_month != '0) &&
    (out_o.out_month <= MONTH_W'(MONTHS)), "illegal date for an in-range day number")

  `ASSERT_IMPLY(cycle_index_a, clk_i, rst_ni, out_o.valid,
    (out_o.day_stem < IDX_W'(STEMS)) && (out_o.branch_idx < IDX_W'(BRANCHES)),
    "stem or branch index out of its cycle")

endmodule

@@ test/dndc_tb_pkg.sv @@
`timescale 1ns / 1ps

package dndc_tb_pkg;
  import dndc_pkg::*;

  typedef enum logic {
    OP_DATE_TO_JDN = 1'b0,
    OP_JDN_TO_DATE = 1'b1
  } conv_op_e;

  typedef struct packed {
    logic [JDN_W-1:0]   day_number;
    logic [DAY_W-1:0]   out_day;
    logic [MONTH_W-1:0] out_month;
    logic [YEAR_W-1:0]  out_year;
    logic [IDX_W-1:0]   day_stem;
    logic [IDX_W-1:0]   branch_idx;
    logic               out_of_range;
  } date_result_t;

endpackage

@@ test/date_conversion_checker.sv @@
`timescale 1ns / 1ps

module date_conversion_checker import dndc_pkg::*; import dndc_tb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  dndc_in_if   in_mon_i,
  dndc_out_if  out_mon_i,
  output int   mismatches_o,
  output int   pending_o
);

  localparam int unsigned ReportLimit = 10;

  date_result_t expected_dates[$];
  int           mismatch_count = 0;

  function automatic date_result_t convert_date(input conv_op_e op,
                                                input logic [DAY_W-1:0] d,
                                                input logic [MONTH_W-1:0] mo,
                                                input logic [YEAR_W-1:0] yr,
                                                input logic [JDN_W-1:0] jdn);
    longint early, ey, em, span, jd, shift, cen, rest, quad, doy, mi;
    date_result_t res;
    res = '0;
    if (op == OP_DATE_TO_JDN) begin
      early = (mo <= FEB) ? 1 : 0;
      ey    = yr + EPOCH_YEAR - early;
      em    = mo + MONTHS * early - MAR_SHIFT;
      span  = d + (DAYS_5M * em + FRAC_ADD) / FRAC_MUL + DAYS_YEAR * ey;
      jd    = span + ey / 4 - ey / CENTURY + ey / 400 - GREG_OFS;
      // fall back to the Julian calendar before the reform
      if (jd < GREG_START) begin
        jd = span + ey / 4 - JUL_OFS;
      end
    end else begin
      jd = jdn;
    end
    res.day_number   = JDN_W'(jd);
    res.day_stem     = IDX_W'((jd + STEM_OFS) % STEMS);
    res.branch_idx   = IDX_W'((jd + BRANCH_OFS) % BRANCHES);
    res.out_of_range = (jd < JD_MIN) || (jd > JD_MAX);
    if (!res.out_of_range) begin
      if (jd >= GREG_START) begin
        shift = jd + GREG_BACK_OFS;
        cen   = (4 * shift + 3) / DAYS_400Y;
        rest  = shift - (cen * DAYS_400Y) / 4;
      end else begin
        cen  = 0;
        rest = jd + JUL_BACK_OFS;
      end
      quad = (4 * rest + 3) / DAYS_4Y;
      doy  = rest - (DAYS_4Y * quad) / 4;
      mi   = (FRAC_MUL * doy + FRAC_ADD) / DAYS_5M;
      res.out_day   = DAY_W'(doy - (DAYS_5M * mi + FRAC_ADD) / FRAC_MUL + 1);
      res.out_month = MONTH_W'(mi + MAR_SHIFT - MONTHS * (mi / LATE_MONTH));
      res.out_year  = YEAR_W'(cen * CENTURY + quad - EPOCH_YEAR + mi / LATE_MONTH);
    end
    return res;
  endfunction

  task automatic check_field(input string field, input longint exp_val,
                             input longint act_val);
    if (exp_val != act_val) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, exp_val,
                 act_val);
      end
    end
  endtask

  always @(posedge clk_i) begin
    date_result_t exp_res;
    if (rst_ni) begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        expected_dates.push_back(convert_date(conv_op_e'(in_mon_i.op), in_mon_i.in_day,
                                              in_mon_i.in_month, in_mon_i.in_year,
                                              in_mon_i.in_day_number));
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_dates.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("%0t: result transaction with none expected, day_number %0d",
                     $realtime, out_mon_i.day_number);
          end
        end else begin
          exp_res = expected_dates.pop_front();
          check_field("day_number", exp_res.day_number, out_mon_i.day_number);
          check_field("out_day", exp_res.out_day, out_mon_i.out_day);
          check_field("out_month", exp_res.out_month, out_mon_i.out_month);
          check_field("out_year", exp_res.out_year, out_mon_i.out_year);
          check_field("day_stem", exp_res.day_stem, out_mon_i.day_stem);
          check_field("branch_idx", exp_res.branch_idx, out_mon_i.branch_idx);
          check_field("out_of_range", exp_res.out_of_range, out_mon_i.out_of_range);
        end
      end
      pending_o    <= expected_dates.size();
      mismatches_o <= mismatch_count;
    end
  end

endmodule

@@ test/tb_day_number_date_converter.sv @@
`timescale 1ns / 1ps

module tb_day_number_date_converter;
  import dndc_pkg::*;
  import dndc_tb_pkg::*;

  localparam int unsigned Latency     = 11;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 120;
  localparam int unsigned PhaseItems  = 300;
  localparam int unsigned Phases      = 4;
  localparam int unsigned SendIdle [Phases] = '{0, 59, 0, 23};
  localparam int unsigned RecvStall[Phases] = '{0, 0, 59, 23};

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  bit          hold_active = 1'b0;
  int unsigned cycle_count = 0;
  int          mismatches;
  int          pending;
  event        hold_go;

  dndc_in_if  in_ch ();
  dndc_out_if out_ch ();

  day_number_date_converter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  date_conversion_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_day_number_date_converter: FAIL");
      $finish;
    end
  end

  initial begin
    forever begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_active <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_active && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_conversion(input conv_op_e op, input logic [DAY_W-1:0] d,
                                 input logic [MONTH_W-1:0] mo,
                                 input logic [YEAR_W-1:0] yr,
                                 input logic [JDN_W-1:0] jdn);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.in_day        <= d;
    in_ch.in_month      <= mo;
    in_ch.in_year       <= yr;
    in_ch.in_day_number <= jdn;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_date(input int unsigned d, input int unsigned mo, input int unsigned yr);
    send_conversion(OP_DATE_TO_JDN, DAY_W'(d), MONTH_W'(mo), YEAR_W'(yr), JDN_W'($urandom));
  endtask

  task automatic send_jdn(input int unsigned jdn);
    send_conversion(OP_JDN_TO_DATE, DAY_W'($urandom), MONTH_W'($urandom), YEAR_W'($urandom),
                    JDN_W'(jdn));
  endtask

  task automatic send_random_conversion();
    int unsigned pick;
    int unsigned pivot;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_date($urandom_range(31, 1), $urandom_range(12, 1), $urandom_range(9999, 1));
    end else if (pick < 55) begin
      send_date($urandom, $urandom, $urandom);
    end else if (pick < 85) begin
      send_jdn($urandom_range(JD_MAX, JD_MIN));
    end else if (pick < 93) begin
      case ($urandom_range(2))
        0: pivot = JD_MIN;
        1: pivot = GREG_START;
        default: pivot = JD_MAX;
      endcase
      send_jdn(pivot + $urandom_range(6) - 3);
    end else begin
      send_jdn($urandom);
    end
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_DATE_TO_JDN;
    in_ch.in_day        = '0;
    in_ch.in_month      = '0;
    in_ch.in_year       = '0;
    in_ch.in_day_number = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_date(1, 1, 1);
    send_date(31, 12, 9999);
    send_date(15, 10, 1582);
    send_date(4, 10, 1582);
    send_date(10, 10, 1582);
    send_date(29, 2, 2000);
    send_date(29, 2, 1900);
    send_date(0, 0, 0);
    send_date(31, 15, 16383);
    send_date(0, 13, 10000);
    send_date(31, 2, 1582);
    send_date(1, 3, 2024);
    send_jdn(0);
    send_jdn(JD_MIN - 1);
    send_jdn(JD_MIN);
    send_jdn(GREG_START - 2);
    send_jdn(GREG_START - 1);
    send_jdn(GREG_START);
    send_jdn(2451545);
    send_jdn(JD_MAX);
    send_jdn(JD_MAX + 1);
    send_jdn(8388607);

    for (int ph = 0; ph < Phases; ph++) begin
      idle_pct  = SendIdle[ph];
      stall_pct = RecvStall[ph];
      // back up the pipeline until the input stalls
      if (ph == 0) begin
        -> hold_go;
      end
      repeat (PhaseItems) send_random_conversion();
    end
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4 * Latency) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb_day_number_date_converter: PASS");
    end else begin
      $display("tb_day_number_date_converter: FAIL");
    end
    $finish;
  end

endmodule
